/* hdl/tqd_pkg.sv */
`timescale 1ns / 1ps

package tqd_pkg;

    localparam int PIX_W      = 7;
    localparam int IN_DEPTH_W = 24;
    localparam int TILES_W    = 4;
    localparam int CFG_IDX_W  = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TILES_ACROSS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_DOWN   = 4'd1;

    // item opcodes
    localparam logic OP_TEST  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic                  opcode;
        logic [PIX_W-1:0]      pixel_x;
        logic [PIX_W-1:0]      pixel_y;
        logic [1:0]            sample_id;
        logic [IN_DEPTH_W-1:0] depth_lane0;
        logic [IN_DEPTH_W-1:0] depth_lane1;
        logic [IN_DEPTH_W-1:0] depth_lane2;
        logic [IN_DEPTH_W-1:0] depth_lane3;
        logic [3:0]            lane_enable;
    } t_item;

    typedef struct packed {
        logic [3:0] pass_bits;
        logic       outside_screen;
    } t_result;

    // what the back end does with a queued command
    typedef enum logic [1:0] {
        K_TEST,
        K_SKIP,
        K_CLEAR
    } t_kind;

    typedef enum logic [1:0] {
        BS_INIT,
        BS_RUN,
        BS_CLEAR
    } t_bstate;

endpackage

/* hdl/tqd_ram.sv */
`timescale 1ns / 1ps

module tqd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/tqd_fifo.sv */
`timescale 1ns / 1ps

module tqd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr_ptr;
    logic [AW:0]      r_rd_ptr;
    logic             w_push;
    logic             w_pop;

    assign o_empty = (r_wr_ptr == r_rd_ptr);
    assign o_full  = (r_wr_ptr[AW] != r_rd_ptr[AW]) && (r_wr_ptr[AW-1:0] == r_rd_ptr[AW-1:0]);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr[AW-1:0]] <= i_wdata;
        end
    end

endmodule

/* hdl/tqd_front.sv */
`timescale 1ns / 1ps

module tqd_front #(
    parameter int TILE_SIZE_LOG2 = 4,
    parameter int MAX_TILES_X    = 8,
    parameter int MAX_TILES_Y    = 8,
    parameter int SAMPLES        = 4,
    parameter int DEPTH_BITS     = 24,
    parameter int ROW_W          = 14,
    parameter int CNT_W          = 15,
    parameter int CMD_W          = 116
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  tqd_pkg::t_item                  i_item,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [tqd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tqd_pkg::TILES_W-1:0]     i_cfg_data,
    input  logic                            i_busy,
    output logic                            o_cmd_valid,
    input  logic                            i_cmd_pop,
    output logic [CMD_W-1:0]                o_cmd,
    output logic [tqd_pkg::TILES_W-1:0]     o_tiles_down,
    output logic [CNT_W-1:0]                o_stride
);

    import tqd_pkg::*;

    localparam int QUADS         = 1 << (TILE_SIZE_LOG2 - 1);
    localparam int ROWS_PER_TILE = SAMPLES * QUADS * QUADS;
    localparam logic [PIX_W-1:0] IN_MASK = PIX_W'((1 << TILE_SIZE_LOG2) - 1);

    typedef struct packed {
        t_kind                          kind;
        logic [ROW_W-1:0]               row;
        logic [3:0][DEPTH_BITS-1:0]     depth;
        logic [3:0]                     lane_en;
    } t_cmd;

    function automatic logic [TILES_W-1:0] sat_x(input logic [TILES_W-1:0] v);
        sat_x = (32'(v) > MAX_TILES_X) ? TILES_W'(MAX_TILES_X) : v;
    endfunction

    function automatic logic [TILES_W-1:0] sat_y(input logic [TILES_W-1:0] v);
        sat_y = (32'(v) > MAX_TILES_Y) ? TILES_W'(MAX_TILES_Y) : v;
    endfunction

    function automatic logic [CNT_W-1:0] stride_of(input logic [TILES_W-1:0] v);
        stride_of = CNT_W'(sat_x(v) * ROWS_PER_TILE);
    endfunction

    logic [TILES_W-1:0] r_across;
    logic [TILES_W-1:0] r_down;
    logic [CNT_W-1:0]   r_stride;
    logic [TILES_W-1:0] w_eff_across;
    logic [PIX_W-1:0]   w_tx;
    logic [PIX_W-1:0]   w_ty;
    logic [PIX_W-1:0]   w_qx;
    logic [PIX_W-1:0]   w_qy;
    logic               w_outside;
    t_cmd               w_cmd;
    logic               w_q_full;
    logic               w_q_empty;
    logic               w_accept;

    assign o_cfg_ready = 1'b1;

    // rows per tile row is kept next to the register so lookup needs one multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_across <= TILES_W'(8);
            r_down   <= TILES_W'(8);
            r_stride <= stride_of(TILES_W'(8));
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_TILES_ACROSS) begin
                r_across <= i_cfg_data;
                r_stride <= stride_of(i_cfg_data);
            end else if (i_cfg_index == REG_TILES_DOWN) begin
                r_down <= i_cfg_data;
            end
        end
    end

    assign w_eff_across = sat_x(r_across);
    assign o_tiles_down = sat_y(r_down);
    assign o_stride     = r_stride;

    // classify: tile, quad and row address
    assign w_tx = i_item.pixel_x >> TILE_SIZE_LOG2;
    assign w_ty = i_item.pixel_y >> TILE_SIZE_LOG2;
    assign w_qx = (i_item.pixel_x & IN_MASK) >> 1;
    assign w_qy = PIX_W'(QUADS - 1) - ((i_item.pixel_y & IN_MASK) >> 1);

    assign w_outside = (w_tx >= PIX_W'(w_eff_across)) || (w_ty >= PIX_W'(o_tiles_down))
                    || (32'(i_item.sample_id) >= SAMPLES);

    always_comb begin
        if (i_item.opcode == OP_CLEAR) begin
            w_cmd.kind = K_CLEAR;
        end else if (w_outside) begin
            w_cmd.kind = K_SKIP;
        end else begin
            w_cmd.kind = K_TEST;
        end
        w_cmd.row = ROW_W'(w_ty * r_stride)
                  + ROW_W'(w_tx * ROWS_PER_TILE)
                  + ROW_W'(i_item.sample_id * (QUADS * QUADS))
                  + ROW_W'(w_qy * QUADS)
                  + ROW_W'(w_qx);
        w_cmd.depth[0] = DEPTH_BITS'(i_item.depth_lane0);
        w_cmd.depth[1] = DEPTH_BITS'(i_item.depth_lane1);
        w_cmd.depth[2] = DEPTH_BITS'(i_item.depth_lane2);
        w_cmd.depth[3] = DEPTH_BITS'(i_item.depth_lane3);
        w_cmd.lane_en  = i_item.lane_enable;
    end

    assign o_full   = i_busy || w_q_full;
    assign w_accept = i_push && !o_full;

    tqd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (4)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_wdata (CMD_W'(w_cmd)),
        .o_full  (w_q_full),
        .i_pop   (i_cmd_pop),
        .o_rdata (o_cmd),
        .o_empty (w_q_empty)
    );

    assign o_cmd_valid = !w_q_empty;

endmodule

/* hdl/tqd_back.sv */
`timescale 1ns / 1ps

module tqd_back #(
    parameter int TILE_SIZE_LOG2 = 4,
    parameter int MAX_TILES_X    = 8,
    parameter int MAX_TILES_Y    = 8,
    parameter int SAMPLES        = 4,
    parameter int DEPTH_BITS     = 24,
    parameter int ROW_W          = 14,
    parameter int CNT_W          = 15,
    parameter int CMD_W          = 116
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_pop,
    input  logic [CMD_W-1:0]            i_cmd,
    input  logic [tqd_pkg::TILES_W-1:0] i_tiles_down,
    input  logic [CNT_W-1:0]            i_stride,
    output logic                        o_busy,
    input  logic                        i_pop,
    output logic                        o_empty,
    output tqd_pkg::t_result            o_result
);

    import tqd_pkg::*;

    localparam int QUADS = 1 << (TILE_SIZE_LOG2 - 1);
    localparam int ROWS  = MAX_TILES_X * MAX_TILES_Y * SAMPLES * QUADS * QUADS;
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    typedef struct packed {
        t_kind                          kind;
        logic [ROW_W-1:0]               row;
        logic [3:0][DEPTH_BITS-1:0]     depth;
        logic [3:0]                     lane_en;
    } t_cmd;

    t_cmd                       w_head;
    t_bstate                    r_state, n_state;
    logic [CNT_W-1:0]           r_clr_row, n_clr_row;
    logic [CNT_W-1:0]           r_clr_end, n_clr_end;
    logic                       r_s1_valid, n_s1_valid;
    t_cmd                       r_s1, n_s1;
    logic [3:0]                 r_fwd_en, n_fwd_en;
    logic [3:0][DEPTH_BITS-1:0] r_fwd_d, n_fwd_d;
    logic [3:0][DEPTH_BITS-1:0] w_rd;
    logic [3:0][DEPTH_BITS-1:0] w_cur;
    logic [3:0]                 w_pass;
    logic [3:0]                 w_s1_we;
    logic                       w_s1_fire;
    logic                       w_walk_we;
    logic                       w_re;
    logic [ROW_W-1:0]           w_waddr;
    t_result                    w_result;
    logic                       w_out_full;
    logic [$bits(t_result)-1:0] w_out_rdata;

    assign w_head = t_cmd'(i_cmd);

    // stage 1: compare against stored depth, the write of the issue cycle forwarded
    always_comb begin
        for (int l = 0; l < 4; l++) begin
            w_cur[l]  = r_fwd_en[l] ? r_fwd_d[l] : w_rd[l];
            w_pass[l] = (r_s1.depth[l] <= w_cur[l]);
        end
    end

    assign w_s1_fire = r_s1_valid && !w_out_full;
    assign w_s1_we   = (w_s1_fire && (r_s1.kind == K_TEST)) ? (w_pass & r_s1.lane_en) : 4'b0;

    always_comb begin
        unique case (r_s1.kind)
            K_TEST: begin
                w_result.pass_bits      = w_pass;
                w_result.outside_screen = 1'b0;
            end
            K_SKIP: begin
                w_result.pass_bits      = 4'b0;
                w_result.outside_screen = 1'b1;
            end
            default: begin
                w_result.pass_bits      = 4'b0;
                w_result.outside_screen = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_INIT;
            r_clr_row  <= '0;
            r_clr_end  <= CNT_W'(ROWS);
            r_s1_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_row  <= n_clr_row;
            r_clr_end  <= n_clr_end;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1     <= n_s1;
        r_fwd_en <= n_fwd_en;
        r_fwd_d  <= n_fwd_d;
    end

    always_comb begin
        n_state    = r_state;
        n_clr_row  = r_clr_row;
        n_clr_end  = r_clr_end;
        n_s1_valid = r_s1_valid && !w_s1_fire;
        n_s1       = r_s1;
        n_fwd_en   = r_fwd_en;
        n_fwd_d    = r_fwd_d;
        o_cmd_pop  = 1'b0;
        o_busy     = 1'b0;
        w_re       = 1'b0;
        w_walk_we  = 1'b0;
        unique case (r_state)
            BS_INIT: begin
                o_busy = 1'b1;
                if (r_clr_row == r_clr_end) begin
                    n_state = BS_RUN;
                end else begin
                    w_walk_we = 1'b1;
                    n_clr_row = r_clr_row + 1'b1;
                end
            end
            BS_RUN: begin
                if (i_cmd_valid && (!r_s1_valid || w_s1_fire)) begin
                    o_cmd_pop = 1'b1;
                    if (w_head.kind == K_CLEAR) begin
                        n_state   = BS_CLEAR;
                        n_clr_row = '0;
                        n_clr_end = CNT_W'(i_tiles_down * i_stride);
                    end else begin
                        w_re       = (w_head.kind == K_TEST);
                        n_s1_valid = 1'b1;
                        n_s1       = w_head;
                        n_fwd_en   = (r_s1_valid && (r_s1.row == w_head.row)) ? w_s1_we : 4'b0;
                        n_fwd_d    = r_s1.depth;
                    end
                end
            end
            BS_CLEAR: begin
                if (r_clr_row == r_clr_end) begin
                    // walk done: hand the clear's result to stage 1
                    n_state    = BS_RUN;
                    n_s1_valid = 1'b1;
                    n_s1.kind  = K_CLEAR;
                    n_fwd_en   = 4'b0;
                end else begin
                    w_walk_we = 1'b1;
                    n_clr_row = r_clr_row + 1'b1;
                end
            end
            default: begin
                n_state = BS_INIT;
            end
        endcase
    end

    assign w_waddr = w_walk_we ? r_clr_row[ROW_W-1:0] : r_s1.row;

    for (genvar l = 0; l < 4; l++) begin : g_lane
        tqd_ram #(
            .WIDTH (DEPTH_BITS),
            .DEPTH (ROWS),
            .AW    (ROW_W)
        ) u_store (
            .i_clk   (i_clk),
            .i_we    (w_walk_we || w_s1_we[l]),
            .i_waddr (w_waddr),
            .i_wdata (w_walk_we ? DEPTH_MAX : r_s1.depth[l]),
            .i_re    (w_re),
            .i_raddr (w_head.row),
            .o_rdata (w_rd[l])
        );
    end

    tqd_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_s1_fire),
        .i_wdata (w_result),
        .o_full  (w_out_full),
        .i_pop   (i_pop),
        .o_rdata (w_out_rdata),
        .o_empty (o_empty)
    );

    assign o_result = t_result'(w_out_rdata);

endmodule

/* hdl/tiled_quad_depth_test_top.sv */
`timescale 1ns / 1ps
// Depth test of one 2x2 quad: one test item per cycle sustained while results are popped
// and no clear runs (one depth read and one write per cycle per lane RAM).
// Clear item: one store row (four lanes) per cycle over tiles_across*tiles_down tiles;
// tests behind it wait in the command queue.
// Reset: synchronous, active low; then a clearing pass of every store row with full held high.
// Configuration writes are taken at any time.

module tiled_quad_depth_test_top #(
    parameter int TILE_SIZE_LOG2 = 4,
    parameter int MAX_TILES_X    = 8,
    parameter int MAX_TILES_Y    = 8,
    parameter int SAMPLES        = 4,
    parameter int DEPTH_BITS     = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input queue side
    input  logic                          push,
    output logic                          full,
    input  tqd_pkg::t_item                i_item,
    // result queue side
    output logic                          empty,
    input  logic                          pop,
    output tqd_pkg::t_result              o_result,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tqd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tqd_pkg::TILES_W-1:0]   i_cfg_data
);

    import tqd_pkg::*;

    // store geometry: one row holds the four lane depths of one quad of one sample
    localparam int QUADS = 1 << (TILE_SIZE_LOG2 - 1);
    localparam int ROWS  = MAX_TILES_X * MAX_TILES_Y * SAMPLES * QUADS * QUADS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W = $clog2(ROWS + 1);
    localparam int CMD_W = $bits(t_kind) + ROW_W + 4 * DEPTH_BITS + 4;

    logic                w_cmd_valid;
    logic                w_cmd_pop;
    logic [CMD_W-1:0]    w_cmd;
    logic [TILES_W-1:0]  w_tiles_down;
    logic [CNT_W-1:0]    w_stride;
    logic                w_busy;

    // front: config registers, tile/quad classification, command queue
    tqd_front #(
        .TILE_SIZE_LOG2 (TILE_SIZE_LOG2),
        .MAX_TILES_X    (MAX_TILES_X),
        .MAX_TILES_Y    (MAX_TILES_Y),
        .SAMPLES        (SAMPLES),
        .DEPTH_BITS     (DEPTH_BITS),
        .ROW_W          (ROW_W),
        .CNT_W          (CNT_W),
        .CMD_W          (CMD_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_item       (i_item),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_busy       (w_busy),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_pop    (w_cmd_pop),
        .o_cmd        (w_cmd),
        .o_tiles_down (w_tiles_down),
        .o_stride     (w_stride)
    );

    // back: read / compare / write pipeline on the lane RAMs, clear walker, result queue
    tqd_back #(
        .TILE_SIZE_LOG2 (TILE_SIZE_LOG2),
        .MAX_TILES_X    (MAX_TILES_X),
        .MAX_TILES_Y    (MAX_TILES_Y),
        .SAMPLES        (SAMPLES),
        .DEPTH_BITS     (DEPTH_BITS),
        .ROW_W          (ROW_W),
        .CNT_W          (CNT_W),
        .CMD_W          (CMD_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (w_cmd_valid),
        .o_cmd_pop    (w_cmd_pop),
        .i_cmd        (w_cmd),
        .i_tiles_down (w_tiles_down),
        .i_stride     (w_stride),
        .o_busy       (w_busy),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (o_result)
    );

    // no item may enter while the post-reset clearing pass runs
    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> full)
        else $error("item could enter during the clearing pass");

    // the clearing pass starts right out of reset
    a_init_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> w_busy)
        else $error("clearing pass not started after reset");

    // an outside quad never reports passing lanes
    a_outside_no_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.outside_screen) |-> (o_result.pass_bits == 4'b0))
        else $error("outside result carries pass bits");

    // full outside the clearing pass means the command queue holds work
    a_full_means_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (full && !w_busy) |-> w_cmd_valid)
        else $error("full with an empty command queue");

endmodule
